// ===== src/spdc_pkg.sv =====
// shared types and constants for the delay compensator
// no dependencies; imported by the top level and the multiplier unit
`default_nettype none

package spdc_pkg;

    // configuration register map, index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_ENABLE       = 2'd0,
        REG_DELAY_LENGTH = 2'd1,
        REG_STRENGTH     = 2'd2,
        REG_FILTER_GAIN  = 2'd3
    } spdc_reg_idx_t;

    localparam int CFG_ADDR_BITS  = 4;
    localparam int CFG_DATA_BITS  = 32;
    localparam int LEN_BITS       = 6;
    localparam int COEF_BITS      = 16;
    localparam int FRAC_BITS      = 8;
    localparam logic [COEF_BITS-1:0] STRENGTH_RESET = 16'd8192;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_DIFF,
        ST_MUL1,
        ST_UPDATE,
        ST_ERR,
        ST_MUL2,
        ST_DONE
    } spdc_state_t;

endpackage

`default_nettype wire

// ===== src/spdc_mul.sv =====
// shared signed-by-unsigned multiplier with registered product
// uses spdc_pkg for the coefficient width
`default_nettype none

module spdc_mul #(
    parameter int A_BITS = 25
) (
    input  wire logic                                        clk,
    input  wire logic                                        en,
    input  wire logic signed [A_BITS-1:0]                    a,
    input  wire logic        [spdc_pkg::COEF_BITS-1:0]       b,
    output logic signed      [A_BITS+spdc_pkg::COEF_BITS-1:0] prod
);
    import spdc_pkg::*;

    localparam int P_BITS = A_BITS + COEF_BITS;

    logic signed [P_BITS-1:0] full;
    logic signed [COEF_BITS:0] b_ext;
    logic signed [P_BITS-1:0] prod_reg;

    assign b_ext = {1'b0, b};
    // unsigned b below 2^16 keeps the product inside P_BITS signed bits
    assign full  = P_BITS'(a) * P_BITS'(b_ext);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= full;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== src/smith_predictor_delay_compensator.sv =====
// smith predictor delay compensator with first-order low-pass on the delayed sample
// depends on spdc_pkg and spdc_mul
// an enabled item steps through write, read, diff, mul1, update, err, mul2 and done;
// a disabled item goes from idle straight to done; items are taken one at a time,
// as set by the single shared multiplier, used twice per enabled item, and the
// one-port ring memory; after reset a clearing pass zeroes the ring while in_ready
// stays low (config writes are taken during it)
`default_nettype none

module smith_predictor_delay_compensator #(
    parameter int DELAY_DEPTH = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // input sample channel
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]         sample_in,
    // output sample channel
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [SAMPLE_BITS-1:0]              sample_out,
    // configuration port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [spdc_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  wire logic [spdc_pkg::CFG_DATA_BITS-1:0]    pwdata,
    output logic [spdc_pkg::CFG_DATA_BITS-1:0]         prdata,
    output logic                                       pready
);
    import spdc_pkg::*;

    // widths
    localparam int SB = SAMPLE_BITS;
    localparam int AW = $clog2(DELAY_DEPTH);       // ring address
    localparam int LW = (AW > LEN_BITS) ? AW : LEN_BITS;
    localparam int FW = SB + FRAC_BITS;            // filter state, 8 fraction bits
    localparam int DW = FW + 1;                    // differences of two Q.8 values
    localparam int PW = DW + COEF_BITS;            // product
    localparam int RW = PW - 22;                   // correction term after rounding

    localparam logic [LW-1:0] LAST_MAX = LW'(DELAY_DEPTH - 1);
    localparam logic signed [PW-1:0] HALF16 = {{(PW-16){1'b0}}, 1'b1, 15'b0};
    localparam logic signed [PW-1:0] HALF22 = {{(PW-22){1'b0}}, 1'b1, 21'b0};
    localparam logic signed [SB+3:0] SAT_HI = {5'b00000, {(SB-1){1'b1}}};
    localparam logic signed [SB+3:0] SAT_LO = {5'b11111, {(SB-1){1'b0}}};

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic                  enable_reg;
    logic [LEN_BITS-1:0]   delay_length_reg;
    logic [COEF_BITS-1:0]  strength_reg;
    logic [COEF_BITS-1:0]  filter_gain_reg;
    logic                  cfg_write;
    spdc_reg_idx_t         cfg_idx;

    assign pready    = 1'b1;
    assign cfg_idx   = spdc_reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= 1'b0;
            delay_length_reg <= '0;
            strength_reg     <= STRENGTH_RESET;
            filter_gain_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_ENABLE:       enable_reg       <= pwdata[0];
                REG_DELAY_LENGTH: delay_length_reg <= pwdata[LEN_BITS-1:0];
                REG_STRENGTH:     strength_reg     <= pwdata[COEF_BITS-1:0];
                REG_FILTER_GAIN:  filter_gain_reg  <= pwdata[COEF_BITS-1:0];
            endcase
        end
    end

    // register read-back, zero-extended
    always_comb
    begin
        unique case (cfg_idx)
            REG_ENABLE:       prdata = CFG_DATA_BITS'(enable_reg);
            REG_DELAY_LENGTH: prdata = CFG_DATA_BITS'(delay_length_reg);
            REG_STRENGTH:     prdata = CFG_DATA_BITS'(strength_reg);
            REG_FILTER_GAIN:  prdata = CFG_DATA_BITS'(filter_gain_reg);
        endcase
    end

    // ---------------------------------------------------------------
    // datapath state
    // ---------------------------------------------------------------
    spdc_state_t               state_reg, state_next;
    logic [AW-1:0]             clr_cnt_reg;
    logic [AW-1:0]             pos_reg;
    logic signed [FW-1:0]      fstate_reg;
    logic signed [SB-1:0]      sample_reg;
    logic signed [SB-1:0]      rd_data_reg;
    logic signed [DW-1:0]      op_a_reg;
    logic [COEF_BITS-1:0]      op_b_reg;
    logic                      out_valid_reg;
    logic signed [SB-1:0]      sample_out_reg;

    // ring memory
    logic signed [SB-1:0]      ring_mem [DELAY_DEPTH];

    // ring length clamp and position advance
    logic [LW-1:0]             len_ext;
    logic [LW-1:0]             last_idx;
    logic [LW:0]               pos_inc;
    logic [AW-1:0]             pos_next;

    assign len_ext  = LW'(delay_length_reg);
    assign last_idx = (len_ext > LAST_MAX) ? LAST_MAX : len_ext;
    assign pos_inc  = (LW+1)'(pos_reg) + (LW+1)'(1);
    // a position left beyond a shortened ring also wraps to zero here
    assign pos_next = (pos_inc > (LW+1)'(last_idx)) ? '0 : pos_inc[AW-1:0];

    // q.8 views of the delayed entry and of the current sample
    logic signed [FW-1:0]      x_q8;
    logic signed [FW-1:0]      samp_q8;
    logic signed [DW-1:0]      diff_val;
    logic signed [DW-1:0]      err_val;

    assign x_q8     = {rd_data_reg, {FRAC_BITS{1'b0}}};
    assign samp_q8  = {sample_reg, {FRAC_BITS{1'b0}}};
    assign diff_val = DW'(x_q8) - DW'(fstate_reg);
    assign err_val  = DW'(samp_q8) - DW'(fstate_reg);

    // shared multiplier
    logic                      mul_en;
    logic signed [PW-1:0]      prod;

    spdc_mul #(
        .A_BITS (DW)
    ) u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (op_a_reg),
        .b    (op_b_reg),
        .prod (prod)
    );

    // rounding: add half, keep the upper bits (arithmetic floor)
    logic signed [PW-1:0]      p16;
    logic signed [PW-1:0]      p22;
    logic signed [DW-1:0]      r16;
    logic signed [RW-1:0]      r22;
    logic signed [DW-1:0]      fstate_sum;
    logic signed [SB+3:0]      out_sum;
    logic signed [SB-1:0]      out_sat;
    logic signed [SB-1:0]      result;

    assign p16        = prod + HALF16;
    assign p22        = prod + HALF22;
    assign r16        = p16[PW-1:16];
    assign r22        = p22[PW-1:22];
    // k below one keeps the filter state inside FW bits
    assign fstate_sum = DW'(fstate_reg) + r16;
    assign out_sum    = (SB+4)'(sample_reg) + (SB+4)'(r22);

    always_comb
    begin
        priority if (out_sum > SAT_HI)
        begin
            out_sat = SAT_HI[SB-1:0];
        end
        else if (out_sum < SAT_LO)
        begin
            out_sat = SAT_LO[SB-1:0];
        end
        else
        begin
            out_sat = out_sum[SB-1:0];
        end
    end

    // bypass if off; user keeps config stable with an item in flight, not enforced
    assign result = enable_reg ? out_sat : sample_reg;

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    logic                      in_beat;
    logic                      out_load;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic signed [SB-1:0]      mem_wdata;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_beat   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign sample_out = sample_out_reg;

    always_comb
    begin
        state_next = state_reg;
        mul_en     = 1'b0;
        out_load   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = pos_reg;
        mem_wdata  = sample_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                // zero one ring entry per cycle after reset
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_cnt_reg == AW'(DELAY_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = enable_reg ? ST_WRITE : ST_DONE;
                end
            end
            ST_WRITE:
            begin
                mem_we     = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:   state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_MUL1;
            ST_MUL1:
            begin
                mul_en     = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: state_next = ST_ERR;
            ST_ERR:    state_next = ST_MUL2;
            ST_MUL2:
            begin
                mul_en     = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // wait here while an earlier result is still held
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            pos_reg       <= '0;
            fstate_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (state_reg == ST_WRITE)
            begin
                pos_reg <= pos_next;
            end
            if (state_reg == ST_UPDATE)
            begin
                fstate_reg <= fstate_sum[FW-1:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            sample_reg <= sample_in;
        end
        if (state_reg == ST_DIFF)
        begin
            op_a_reg <= diff_val;
            op_b_reg <= filter_gain_reg;
        end
        if (state_reg == ST_ERR)
        begin
            op_a_reg <= err_val;
            op_b_reg <= strength_reg;
        end
        if (out_load)
        begin
            sample_out_reg <= result;
        end
    end

    // ring memory: one write port, registered read of the oldest entry
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == ST_READ)
        begin
            rd_data_reg <= ring_mem[pos_reg];
        end
    end

endmodule

`default_nettype wire

// ===== src/spdc_checker.sv =====
// port-level checks for the delay compensator
// depends on spdc_pkg; bound to smith_predictor_delay_compensator below
`default_nettype none

module spdc_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic signed [SAMPLE_BITS-1:0]  sample_out,
    input wire logic                           pready
);
    import spdc_pkg::*;

    // a held result beat keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out))
        else $error("output beat changed while stalled");

    // one item at a time: busy right after an input beat
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again while an item is in work");

    // a new result only comes out of a busy cycle
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without an item in work");

    // ring clearing pass right after reset keeps the input closed
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !in_ready && pready)
        else $error("input open during clearing pass");

endmodule

bind smith_predictor_delay_compensator spdc_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_spdc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .pready     (pready)
);

`default_nettype wire
